// ----- rtl/decayed_frequency_table_topk_unit_macros.svh -----
// assertion macros for the frequency table block
`ifndef DECAYED_FREQUENCY_TABLE_TOPK_UNIT_MACROS_SVH
`define DECAYED_FREQUENCY_TABLE_TOPK_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define DFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define DFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/dft_pkg.sv -----
// shared types and constants for the frequency table block
package dft_pkg;
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned MaxResultsDef = 16;
  localparam logic [31:0] WeightOne = 32'h0001_0000;
  localparam logic [31:0] WeightMax = 32'hFFFF_FFFF;
  localparam logic [15:0] DecayReset = 16'd64225;
  localparam logic FuncRecord = 1'b0;
  localparam logic FuncQuery = 1'b1;
  localparam logic [0:0] RegDecay = 1'b0;

  typedef struct packed {
    logic       func;
    logic [7:0] layer_id;
    logic [7:0] expert_sel;
    logic [4:0] query_limit;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  expert;
    logic [31:0] weight;
    logic        last;
  } res_t;
endpackage

// ----- rtl/dft_ram.sv -----
// generic single-port ram with registered read
module dft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/dft_front.sv -----
// input side: accepts items into a short command queue
module dft_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  dft_pkg::cmd_t cmd_i,
  output logic          cmd_valid_o,
  input  logic          cmd_take_i,
  output dft_pkg::cmd_t cmd_o
);
  import dft_pkg::*;
  `include "decayed_frequency_table_topk_unit_macros.svh"

  cmd_t        slot_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o      = cnt_q[1];
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = slot_q[rp_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `DFT_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3, "queue count overflow")
  `DFT_ASSERT_NEXT(a_push_cnt, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 2'd1,
    "push lost")
  `DFT_ASSERT_IMP(a_ptr_sync, clk_i, rst_ni, cnt_q == 2'd0 || cnt_q == 2'd2, wp_q == rp_q,
    "pointers out of step")
endmodule

// ----- rtl/dft_back.sv -----
// execution side: scans, updates and ages the table and sorts query matches into a top list
module dft_back #(
  parameter int unsigned TableDepth = dft_pkg::TableDepthDef,
  parameter int unsigned MaxResults = dft_pkg::MaxResultsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   decay_i,
  input  logic          cmd_valid_i,
  output logic          cmd_take_o,
  input  dft_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_take_i,
  output dft_pkg::res_t res_o
);
  import dft_pkg::*;
  `include "decayed_frequency_table_topk_unit_macros.svh"

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned SelW = (MaxResults > 1) ? $clog2(MaxResults) : 1;
  localparam int unsigned LenW = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_HIT, S_DECAY_RD, S_DECAY_MUL, S_DECAY_WR, S_WRITE,
    S_Q_SCAN, S_OUT, S_EMPTY
  } state_e;

  state_e          state_q;
  cmd_t            cmd_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] idx_q;
  logic [IdxW-1:0] victim_q;
  logic [31:0]     low_q;
  logic [47:0]     prod_q;
  logic [IdxW-1:0] mul_idx_q;
  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;
  logic [31:0]     hit_w_q;

  // sorted top list
  logic [31:0]     top_w_q [MaxResults];
  logic [7:0]      top_e_q [MaxResults];
  logic [LenW-1:0] top_n_q;
  logic [LenW-1:0] lim_q;
  logic [SelW-1:0] out_q;

  // result register
  logic res_valid_q;
  res_t res_q;

  // memory
  logic            we;
  logic [IdxW-1:0] addr;
  logic [7:0]      wl, we_x, rl, rx;
  logic [31:0]     ww, rw;

  dft_ram #(.Width(8), .Depth(TableDepth)) u_layer (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wl), .rdata_o(rl));
  dft_ram #(.Width(8), .Depth(TableDepth)) u_expert (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(we_x), .rdata_o(rx));
  dft_ram #(.Width(32), .Depth(TableDepth)) u_weight (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(ww), .rdata_o(rw));

  logic            full_tab;
  logic            last_rd;
  logic [31:0]     decayed;
  logic [LenW-1:0] lim_c;
  logic            res_free;
  logic            res_load;

  assign full_tab = count_q == CntW'(TableDepth);
  assign last_rd  = idx_q == count_q;
  assign decayed  = prod_q[47:16];
  assign res_free = !res_valid_q || res_take_i;
  assign res_load = res_free && ((state_q == S_OUT && lim_q != '0 && top_n_q != '0) ||
                                 state_q == S_EMPTY);
  assign lim_c    = (32'(cmd_i.query_limit) > MaxResults) ? LenW'(MaxResults)
                                                          : LenW'(cmd_i.query_limit);

  // memory address, write data; read data is valid in the cycle after the address
  always_comb begin
    we   = 1'b0;
    addr = idx_q[IdxW-1:0];
    wl   = cmd_q.layer_id;
    we_x = cmd_q.expert_sel;
    ww   = WeightOne;
    unique case (state_q)
      S_HIT: begin
        we   = 1'b1;
        addr = pend_idx_q;
        ww   = (hit_w_q > WeightMax - WeightOne) ? WeightMax : hit_w_q + WeightOne;
      end
      S_DECAY_WR: begin
        we   = 1'b1;
        addr = mul_idx_q;
        wl   = rl;
        we_x = rx;
        ww   = decayed;
      end
      S_WRITE: begin
        we   = 1'b1;
        addr = full_tab ? victim_q : count_q[IdxW-1:0];
      end
      S_DECAY_RD, S_DECAY_MUL: addr = mul_idx_q;
      default: ;
    endcase
  end

  assign cmd_take_o  = state_q == S_IDLE && cmd_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // insertion of the current read into the top list
  logic [31:0] ins_w [MaxResults];
  logic [7:0]  ins_e [MaxResults];
  logic        gt    [MaxResults];
  always_comb begin
    for (int k = 0; k < MaxResults; k++) begin
      gt[k] = (LenW'(k) >= top_n_q) || (top_w_q[k] < rw);
    end
    for (int k = 0; k < MaxResults; k++) begin
      if (!gt[k]) begin
        ins_w[k] = top_w_q[k];
        ins_e[k] = top_e_q[k];
      end else if (k == 0 || !gt[(k > 0) ? k - 1 : 0]) begin
        ins_w[k] = rw;
        ins_e[k] = rx;
      end else begin
        ins_w[k] = top_w_q[(k > 0) ? k - 1 : 0];
        ins_e[k] = top_e_q[(k > 0) ? k - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= rw * decay_i;
    // weight of the entry being checked, kept for the hit update
    if (state_q == S_SCAN) hit_w_q <= rw;
    if (cmd_take_o) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      victim_q    <= '0;
      low_q       <= '0;
      mul_idx_q   <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      top_n_q     <= '0;
      lim_q       <= '0;
      out_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      for (int k = 0; k < MaxResults; k++) begin
        top_w_q[k] <= '0;
        top_e_q[k] <= '0;
      end
    end else begin
      if (res_load) res_valid_q <= 1'b1;
      else if (res_take_i) res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          idx_q   <= '0;
          pend_q  <= 1'b0;
          top_n_q <= '0;
          lim_q   <= lim_c;
          out_q   <= '0;
          if (cmd_valid_i) begin
            state_q <= (cmd_i.func == FuncQuery) ? S_Q_SCAN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (pend_q && rl == cmd_q.layer_id && rx == cmd_q.expert_sel) begin
            state_q <= S_HIT;
          end else if (last_rd) begin
            if (full_tab) begin
              mul_idx_q <= '0;
              state_q   <= S_DECAY_RD;
            end else begin
              state_q <= S_WRITE;
            end
          end else begin
            pend_idx_q <= idx_q[IdxW-1:0];
            pend_q     <= 1'b1;
            idx_q      <= idx_q + 1'b1;
          end
        end
        S_HIT: state_q <= S_IDLE;
        S_DECAY_RD: state_q <= S_DECAY_MUL;
        S_DECAY_MUL: state_q <= S_DECAY_WR;
        S_DECAY_WR: begin
          if (mul_idx_q == '0 || decayed < low_q) begin
            low_q    <= decayed;
            victim_q <= mul_idx_q;
          end
          if (CntW'(mul_idx_q) == CntW'(TableDepth - 1)) begin
            state_q <= S_WRITE;
          end else begin
            mul_idx_q <= mul_idx_q + 1'b1;
            state_q   <= S_DECAY_RD;
          end
        end
        S_WRITE: begin
          if (!full_tab) count_q <= count_q + 1'b1;
          state_q <= S_IDLE;
        end
        S_Q_SCAN: begin
          if (pend_q && rl == cmd_q.layer_id) begin
            for (int k = 0; k < MaxResults; k++) begin
              top_w_q[k] <= ins_w[k];
              top_e_q[k] <= ins_e[k];
            end
            if (top_n_q != LenW'(MaxResults)) top_n_q <= top_n_q + 1'b1;
          end
          if (last_rd) begin
            pend_q <= 1'b0;
            state_q <= S_OUT;
          end else begin
            pend_q <= 1'b1;
            idx_q  <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          if (lim_q == '0 || top_n_q == '0) begin
            state_q <= S_EMPTY;
          end else if (res_free) begin
            res_q.found  <= 1'b1;
            res_q.expert <= top_e_q[out_q];
            res_q.weight <= top_w_q[out_q];
            if (LenW'(out_q) + 1'b1 == lim_q || LenW'(out_q) + 1'b1 == top_n_q) begin
              res_q.last <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              res_q.last <= 1'b0;
              out_q      <= out_q + 1'b1;
            end
          end
        end
        S_EMPTY: begin
          if (res_free) begin
            res_q       <= '{found: 1'b0, expert: 8'd0, weight: 32'd0, last: 1'b1};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `DFT_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CntW'(TableDepth),
    "entry count beyond depth")
  `DFT_ASSERT_IMP(a_top_max, clk_i, rst_ni, 1'b1, top_n_q <= LenW'(MaxResults),
    "top list overflow")
  `DFT_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_q && !res_take_i,
    res_valid_q && $stable(res_q), "result changed while waiting")
endmodule

// ----- rtl/decayed_frequency_table_topk_unit.sv -----
// top level of the expert frequency table with aging and top-k query
// an item is a record or a query. records look up (layer, expert) by reading the
// table one entry a cycle; a miss on a full table adds a decay sweep over every entry
// (read, multiply, write back) and then replaces the lowest decayed entry. queries
// scan all entries, keeping a sorted list of the best MAX_RESULTS matches on the layer,
// then emit one result item a cycle while the receiver takes them. the single-port
// table memory sets the pace of scans and sweeps. a two-entry queue sits in front,
// so items are taken while the back end is busy; results leave from a register.
// the decay factor register sits at address 0 and resets to 0.98 in Q0.16.
module decayed_frequency_table_topk_unit #(
  parameter int unsigned TABLE_DEPTH = dft_pkg::TableDepthDef,
  parameter int unsigned MAX_RESULTS = dft_pkg::MaxResultsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [7:0]  layer_id_i,
  input  logic [7:0]  expert_sel_i,
  input  logic [4:0]  query_limit_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [7:0]  expert_out_o,
  output logic [31:0] weight_out_o,
  output logic        last_o
);
  import dft_pkg::*;

  logic [15:0] decay_q;
  cmd_t        cmd_in, cmd_head;
  logic        cmd_valid, cmd_take, res_valid;
  res_t        res;

  // config register, index is byte address / 2
  assign pready = 1'b1;
  assign prdata = (paddr[1:1] == RegDecay) ? {16'd0, decay_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DecayReset;
    end else if (psel && penable && pwrite && paddr[1:1] == RegDecay) begin
      decay_q <= pwdata[15:0];
    end
  end

  assign cmd_in = '{func: func_i, layer_id: layer_id_i, expert_sel: expert_sel_i,
                    query_limit: query_limit_i};

  dft_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(cmd_in),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd_head));

  dft_back #(.TableDepth(TABLE_DEPTH), .MaxResults(MAX_RESULTS)) u_back (
    .clk_i, .rst_ni, .decay_i(decay_q), .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .cmd_i(cmd_head), .res_valid_o(res_valid), .res_take_i(pop), .res_o(res));

  assign empty        = !res_valid;
  assign found_o      = res.found;
  assign expert_out_o = res.expert;
  assign weight_out_o = res.weight;
  assign last_o       = res.last;
endmodule

// ----- test/decayed_frequency_table_topk_unit_checker.sv -----
// checker for the frequency table: tracks the table, predicts query results, compares outputs
module decayed_frequency_table_topk_unit_checker
  import dft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        push,
  input  logic        full,
  input  logic        func_i,
  input  logic [7:0]  layer_id_i,
  input  logic [7:0]  expert_sel_i,
  input  logic [4:0]  query_limit_i,
  input  logic        empty,
  input  logic        pop,
  input  logic        found_o,
  input  logic [7:0]  expert_out_o,
  input  logic [31:0] weight_out_o,
  input  logic        last_o,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int Depth = int'(TableDepthDef);
  localparam int MaxOut = int'(MaxResultsDef);
  localparam logic [1:0] DecayAddr = 2'(4 * RegDecay);

  logic [7:0]  tab_layer[Depth];
  logic [7:0]  tab_expert[Depth];
  logic [31:0] tab_weight[Depth];
  int          tab_count;
  logic [15:0] decay;
  res_t        ranked_q[$];

  task automatic count_route(input logic [7:0] layer, input logic [7:0] expert);
    int j;
    int victim;
    bit hit;
    logic [31:0] low;
    logic [63:0] prod;
    hit = 0;
    for (j = 0; j < tab_count; j++) begin
      if (!hit && tab_layer[j] == layer && tab_expert[j] == expert) begin
        hit = 1;
        if (tab_weight[j] > WeightMax - WeightOne) tab_weight[j] = WeightMax;
        else tab_weight[j] = tab_weight[j] + WeightOne;
      end
    end
    if (hit) return;
    if (tab_count >= Depth) begin
      // age every entry, then evict the first lowest
      victim = 0;
      low = '0;
      for (j = 0; j < Depth; j++) begin
        prod = {32'd0, tab_weight[j]} * {48'd0, decay};
        tab_weight[j] = prod[47:16];
        if (j == 0 || tab_weight[j] < low) begin
          low = tab_weight[j];
          victim = j;
        end
      end
      tab_layer[victim] = layer;
      tab_expert[victim] = expert;
      tab_weight[victim] = WeightOne;
    end else begin
      tab_layer[tab_count] = layer;
      tab_expert[tab_count] = expert;
      tab_weight[tab_count] = WeightOne;
      tab_count++;
    end
  endtask

  task automatic rank_layer(input logic [7:0] layer, input logic [4:0] limit);
    int order[Depth];
    int m;
    int i;
    int pos;
    int take;
    res_t r;
    m = 0;
    for (i = 0; i < tab_count; i++) begin
      if (tab_layer[i] == layer) begin
        // stable insert, only pass strictly lower weights
        pos = m;
        while (pos > 0 && tab_weight[order[pos - 1]] < tab_weight[i]) begin
          order[pos] = order[pos - 1];
          pos--;
        end
        order[pos] = i;
        m++;
      end
    end
    take = limit;
    if (take > MaxOut) take = MaxOut;
    if (take > m) take = m;
    if (take == 0) begin
      r = '{found: 1'b0, expert: 8'd0, weight: 32'd0, last: 1'b1};
      ranked_q.push_back(r);
    end
    for (i = 0; i < take; i++) begin
      r.found = 1'b1;
      r.expert = tab_expert[order[i]];
      r.weight = tab_weight[order[i]];
      r.last = (i + 1 == take);
      ranked_q.push_back(r);
    end
  endtask

  task automatic flag_error(input string what, input res_t want);
    if (fail_count_o < 10) begin
      $display("mismatch %s: exp found=%0b expert=%0d weight=%h last=%0b",
               what, want.found, want.expert, want.weight, want.last);
      $display("  got found=%0b expert=%0d weight=%h last=%0b",
               found_o, expert_out_o, weight_out_o, last_o);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      tab_count = 0;
      decay = DecayReset;
      ranked_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == DecayAddr) decay = pwdata[15:0];
      if (pop && !empty) begin
        if (ranked_q.size() == 0) begin
          want = '0;
          flag_error("unexpected item", want);
        end else begin
          want = ranked_q.pop_front();
          if (found_o !== want.found || expert_out_o !== want.expert ||
              weight_out_o !== want.weight || last_o !== want.last)
            flag_error("result", want);
        end
      end
      if (push && !full) begin
        if (func_i == FuncRecord) count_route(layer_id_i, expert_sel_i);
        else rank_layer(layer_id_i, query_limit_i);
      end
      pending_o = ranked_q.size();
    end
  end
endmodule

// ----- test/testbench.sv -----
// top of the frequency table test: stimulus, register writes, watchdog and verdict
module testbench;
  import dft_pkg::*;

  localparam int HoldCycles = 1200;   // margin for full-table records with decay sweeps, two queued
  localparam int WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        func_i = FuncRecord;
  logic [7:0]  layer_id_i = '0;
  logic [7:0]  expert_sel_i = '0;
  logic [4:0]  query_limit_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        found_o;
  logic [7:0]  expert_out_o;
  logic [31:0] weight_out_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  decayed_frequency_table_topk_unit uut (.*);

  decayed_frequency_table_topk_unit_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .push, .full, .func_i, .layer_id_i, .expert_sel_i, .query_limit_i,
    .empty, .pop, .found_o, .expert_out_o, .weight_out_o, .last_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: stall length is redrawn from the idle counter's phase, some windows never stall
  always @(negedge clk_i) begin
    int phase_cnt;
    int stall_len;
    phase_cnt = idle_cycles % 48;
    if (phase_cnt == 0) stall_len = $urandom_range(0, 5);
    pop <= ((idle_cycles % 7) >= stall_len);
  end

  // watchdog: cycles without any accepted item on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL decayed_frequency_table_topk_unit");
        $finish;
      end
    end
  end

  // one item; the sender runs in bursts with random gaps between them
  task automatic send_item(input logic f, input logic [7:0] layer, input logic [7:0] expert,
                           input logic [4:0] limit);
    int gap;
    if (burst_left == 0) begin
      @(negedge clk_i);
      push = 1'b0;
      gap = $urandom_range(0, 6);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 8);
    end else begin
      @(negedge clk_i);
    end
    push = 1'b1;
    func_i = f;
    layer_id_i = layer;
    expert_sel_i = expert;
    query_limit_i = limit;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  // register write, only while nothing is in flight
  task automatic write_decay(input logic [15:0] value);
    @(negedge clk_i);
    push = 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (HoldCycles) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 2'(4 * RegDecay);
    pwdata = {16'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // mostly well-formed traffic on a few layers so the table fills and evicts
  task automatic random_items(input int count);
    int k;
    int pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        send_item(FuncRecord, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 23)),
                  5'($urandom_range(0, 31)));
      else if (pick < 72)
        send_item(FuncRecord, 8'($urandom), 8'($urandom), 5'($urandom));
      else if (pick < 94)
        send_item(FuncQuery, 8'($urandom_range(0, 3)), 8'($urandom),
                  5'($urandom_range(0, 31)));
      else
        send_item(FuncQuery, 8'($urandom), 8'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, hit, limits zero, one, max and above max
    send_item(FuncQuery, 8'd0, 8'd0, 5'd16);
    send_item(FuncRecord, 8'd255, 8'd255, 5'd31);
    send_item(FuncRecord, 8'd0, 8'd0, 5'd0);
    send_item(FuncRecord, 8'd255, 8'd255, 5'd0);
    send_item(FuncRecord, 8'd255, 8'd0, 5'd0);
    send_item(FuncRecord, 8'd255, 8'd128, 5'd0);
    send_item(FuncRecord, 8'd255, 8'd128, 5'd0);
    send_item(FuncRecord, 8'd255, 8'd128, 5'd0);
    send_item(FuncQuery, 8'd255, 8'd255, 5'd31);
    send_item(FuncQuery, 8'd255, 8'd0, 5'd16);
    send_item(FuncQuery, 8'd255, 8'd0, 5'd1);
    send_item(FuncQuery, 8'd255, 8'd0, 5'd0);
    send_item(FuncQuery, 8'd7, 8'd0, 5'd4);
    send_item(FuncQuery, 8'd0, 8'd0, 5'd2);

    // random phases over several decay settings; each write also drains everything
    random_items(25);
    write_decay(16'd0);
    random_items(25);
    write_decay(16'hFFFF);
    random_items(25);
    write_decay(16'($urandom));
    random_items(15);

    @(negedge clk_i);
    push = 1'b0;
    wait (pending == 0);
    repeat (HoldCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS decayed_frequency_table_topk_unit");
    end else begin
      $display("FAIL decayed_frequency_table_topk_unit");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/dft_pkg.sv
rtl/dft_ram.sv
rtl/dft_front.sv
rtl/dft_back.sv
rtl/decayed_frequency_table_topk_unit.sv
test/decayed_frequency_table_topk_unit_checker.sv
test/testbench.sv
